/* hdl/slir_pkg.sv */
// sorted list package: status and mode codes, control and flag structs between top and cells
// no dependencies
package slir_pkg;

    localparam logic       MODE_INSERT = 1'b0;
    localparam logic       MODE_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_MISSING  = 2'd3;

    localparam int         STATUS_W    = 2;
    localparam int         KEY_FIELD_W = 32;
    localparam int         COUNT_W     = 5;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } cell_ctrl_t;

    // per-cell compare results
    typedef struct packed {
        logic after;
        logic ge;
        logic eq;
    } cell_flags_t;

endpackage

/* hdl/slir_if.sv */
// request and response channel interfaces for the sorted list
// depends on slir_pkg
interface slir_req_if;
    import slir_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [KEY_FIELD_W-1:0] key_value;

    modport source (output valid, output mode, output key_value, input ready);
    modport sink   (input valid, input mode, input key_value, output ready);
endinterface

interface slir_rsp_if;
    import slir_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [KEY_FIELD_W-1:0] removed_value;
    logic [COUNT_W-1:0]     item_count;

    modport source (output valid, output status, output removed_value, output item_count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input item_count,
                    output ready);
endinterface

/* hdl/slir_cell.sv */
// one storage cell of the sorted list: holds a key, compares it and shifts with neighbors
// depends on slir_pkg
module slir_cell #(
    parameter int KEY_WIDTH = 32,
    parameter int CNT_W     = 5,
    parameter int CELL_IDX  = 0
) (
    input  logic                 clk,
    input  logic [KEY_WIDTH-1:0] key,
    input  logic [CNT_W-1:0]     count,
    input  slir_pkg::cell_ctrl_t ctrl,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic                 left_after,
    input  logic [KEY_WIDTH-1:0] right_key,
    output slir_pkg::cell_flags_t flags,
    output logic [KEY_WIDTH-1:0] stored
);
    import slir_pkg::*;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 occupied;

    assign occupied = CNT_W'(CELL_IDX) < count;

    always_comb
    begin
        flags.after = !occupied || (key < key_reg);
        flags.ge    = occupied && (key_reg >= key);
        flags.eq    = occupied && (key_reg == key);
    end

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.shift_up && flags.after)
        begin
            key_next = left_after ? left_key : key;
        end
        else if (ctrl.shift_down && flags.ge)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign stored = key_reg;

endmodule

/* hdl/sorted_list_insert_remove_top.sv */
// sorted list top level: request decode, count, row of cells and response register
// depends on slir_pkg, slir_if, slir_cell
//
// keeps up to DEPTH keys in ascending order in a row of cells
// req channel: mode (insert or remove) and key_value; one response per request
// rsp channel: status, removed_value, item_count after the operation
// insert places the key after all equal keys and shifts larger keys up one cell;
// a full list answers full and keeps its contents
// remove takes out the first equal key and shifts larger keys down one cell;
// an empty list answers empty, a missing key answers not found
// every cell compares against the request key in the same cycle, so one request
// is taken per clock while rsp is not stalled, and its response appears in the cycle after acceptance
// the response register frees in the cycle it is taken, so req.ready is high
// whenever the register is empty or being drained; a stalled rsp holds its data
// and blocks new requests until taken
// reset empties the list (count to zero) and clears the response valid flag;
// the first request can be taken in the first cycle after reset
module sorted_list_insert_remove_top #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    slir_req_if.sink   req,
    slir_rsp_if.source rsp
);
    import slir_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    logic [STATUS_W-1:0]    status_reg;
    logic [STATUS_W-1:0]    status_next;
    logic [KEY_FIELD_W-1:0] removed_reg;
    logic [KEY_FIELD_W-1:0] removed_next;

    logic                   accept;
    logic                   full;
    logic                   empty;
    logic                   found;
    logic [KEY_WIDTH-1:0]   key;
    cell_ctrl_t             ctrl;

    logic [KEY_WIDTH-1:0]   stored [DEPTH];
    cell_flags_t            flags  [DEPTH];
    logic [DEPTH-1:0]       eq_vec;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign key       = KEY_WIDTH'(req.key_value);
    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign found     = |eq_vec;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] left_key;
        logic                 left_after;
        logic [KEY_WIDTH-1:0] right_key;

        if (i == 0)
        begin : g_first
            assign left_key   = '0;
            assign left_after = 1'b0;
        end
        else
        begin : g_inner
            assign left_key   = stored[i-1];
            assign left_after = flags[i-1].after;
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_key = stored[i];
        end
        else
        begin : g_mid
            assign right_key = stored[i+1];
        end

        assign eq_vec[i] = flags[i].eq;

        slir_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CNT_W),
            .CELL_IDX  (i)
        ) u_cell (
            .clk        (clk),
            .key        (key),
            .count      (count_reg),
            .ctrl       (ctrl),
            .left_key   (left_key),
            .left_after (left_after),
            .right_key  (right_key),
            .flags      (flags[i]),
            .stored     (stored[i])
        );
    end

    always_comb
    begin
        ctrl           = '0;
        count_next     = count_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            removed_next   = '0;
            unique case (req.mode)
                MODE_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.shift_up = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        status_next   = ST_OK;
                    end
                end
                MODE_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (!found)
                    begin
                        status_next = ST_MISSING;
                    end
                    else
                    begin
                        ctrl.shift_down = 1'b1;
                        count_next      = count_reg - CNT_W'(1);
                        status_next     = ST_OK;
                        removed_next    = KEY_FIELD_W'(key);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.item_count    = COUNT_W'(count_reg);

endmodule

/* hdl/slir_checker.sv */
// port-level checks for the sorted list top level, attached by bind
// depends on slir_pkg and sorted_list_insert_remove_top
module slir_checker #(
    parameter int DEPTH = 16
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [slir_pkg::STATUS_W-1:0]    status,
    input logic [slir_pkg::KEY_FIELD_W-1:0] removed_value,
    input logic [slir_pkg::COUNT_W-1:0]     item_count
);
    import slir_pkg::*;

    // stalled response keeps its status and item count
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(item_count))
        else $error("response changed while stalled");

    // req_ready is high whenever the response slot is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request blocked with empty response slot");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> item_count == COUNT_W'(DEPTH))
        else $error("full status with wrong count");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |-> item_count == '0)
        else $error("empty status with nonzero count");

    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> removed_value == '0)
        else $error("removed value set on failed request");

endmodule

bind sorted_list_insert_remove_top slir_checker #(
    .DEPTH (DEPTH)
) u_slir_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .removed_value (rsp.removed_value),
    .item_count    (rsp.item_count)
);
